@@ hw/rtl/http_method_token_recognizer_defines.svh @@
// Assertion macros for the HTTP method token recognizer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef HTTP_METHOD_TOKEN_RECOGNIZER_DEFINES_SVH
`define HTTP_METHOD_TOKEN_RECOGNIZER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define HMTR_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hmtr assertion failed");

// The consequent holds in the cycle after the antecedent.
`define HMTR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hmtr assertion failed");

`endif

@@ hw/rtl/hmtr_pkg.sv @@
// Types, constants and method name tables for the HTTP method token recognizer.
// Used by the result channel interface and the top level; depends on nothing.
`default_nettype none

package hmtr_pkg;

  localparam int NUM_METHODS = 8;
  localparam int NAME_SLOTS  = 8;
  localparam int POS_W       = 4;

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [NUM_METHODS-1:0] match_t;

  typedef enum logic [3:0] {
    METHOD_NOT_IMPLEMENTED = 4'd0,
    METHOD_OPTIONS         = 4'd1,
    METHOD_GET             = 4'd2,
    METHOD_HEAD            = 4'd3,
    METHOD_POST            = 4'd4,
    METHOD_PUT             = 4'd5,
    METHOD_DELETE          = 4'd6,
    METHOD_TRACE           = 4'd7,
    METHOD_CONNECT         = 4'd8
  } method_code_t;

  function automatic logic [8*NAME_SLOTS-1:0] method_name(input logic [2:0] k);
    logic [8*NAME_SLOTS-1:0] name;
    case (k)
      3'd0: name = {"OPTIONS", 8'h00};
      3'd1: name = {"GET", 40'h0};
      3'd2: name = {"HEAD", 32'h0};
      3'd3: name = {"POST", 32'h0};
      3'd4: name = {"PUT", 40'h0};
      3'd5: name = {"DELETE", 16'h0};
      3'd6: name = {"TRACE", 24'h0};
      3'd7: name = {"CONNECT", 8'h00};
      default: name = '0;
    endcase
    return name;
  endfunction

  function automatic logic [7:0] method_char(input logic [2:0] k, input logic [2:0] slot);
    logic [8*NAME_SLOTS-1:0] name;
    logic [2:0]              rev;
    name = method_name(k);
    rev  = 3'd7 - slot;
    return name[{rev, 3'b000} +: 8];
  endfunction

  function automatic pos_t method_len(input logic [2:0] k);
    pos_t len;
    case (k)
      3'd0: len = 4'd7;
      3'd1: len = 4'd3;
      3'd2: len = 4'd4;
      3'd3: len = 4'd4;
      3'd4: len = 4'd3;
      3'd5: len = 4'd6;
      3'd6: len = 4'd5;
      3'd7: len = 4'd7;
      default: len = '0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hmtr_in_if.sv @@
// Input channel of the HTTP method token recognizer: one request line byte per beat.
// Depends on nothing.
`default_nettype none

interface hmtr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       token_start;

  modport source (output valid, output data_byte, output token_start, input ready);
  modport sink (input valid, input data_byte, input token_start, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hmtr_out_if.sv @@
// Result channel of the HTTP method token recognizer: one method code per beat.
// Depends on hmtr_pkg for the method code type.
`default_nettype none

interface hmtr_out_if;
  logic                  valid;
  logic                  ready;
  hmtr_pkg::method_code_t method_code;

  modport source (output valid, output method_code, input ready);
  modport sink (input valid, input method_code, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/http_method_token_recognizer.sv @@
// Top level of the HTTP method token recognizer.
// Depends on hmtr_pkg, hmtr_in_if, hmtr_out_if and the assertion macro header.
//
// Accepts one byte of an HTTP request line per beat, at one beat per clock, and
// emits one method code beat for each token closed by a space. A byte first lands
// in an input register; as it leaves that register it updates the per-method match mask
// and position counter and, on a space, loads the result register; so a space byte passes
// the input register and then the result register before its result is presented, which
// holds while the result channel stalls. A held result stalls the input register, and
// through it the input. Bytes outside a token produce nothing.
// Tokens longer than MAX_TOKEN_LEN bytes, or with no exact match, report not implemented.
`default_nettype none

`include "http_method_token_recognizer_defines.svh"

module http_method_token_recognizer #(
  parameter int MAX_TOKEN_LEN = 8
) (
  input  wire          clk,
  input  wire          rst_n,
  hmtr_in_if.sink      in_if,
  hmtr_out_if.source   out_if
);

  localparam hmtr_pkg::pos_t MAX_POS = hmtr_pkg::pos_t'(MAX_TOKEN_LEN);

  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic [7:0]             s1_byte_r;
  logic                   s1_start_r;
  logic                   s1_fire;

  hmtr_pkg::match_t       match_r;
  hmtr_pkg::match_t       match_nxt;
  hmtr_pkg::pos_t         pos_r;
  hmtr_pkg::pos_t         pos_nxt;
  logic                   active_r;
  logic                   active_nxt;

  logic                   out_valid_r;
  logic                   out_valid_nxt;
  hmtr_pkg::method_code_t code_r;
  hmtr_pkg::method_code_t code_nxt;

  logic                   emit;
  hmtr_pkg::match_t       cur_match;
  hmtr_pkg::pos_t         cur_pos;
  logic                   cur_active;

  assign s1_fire     = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_fire;
  assign s1_valid_nxt = (in_if.valid && in_if.ready) || (s1_valid_r && !s1_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_byte_r  <= in_if.data_byte;
      s1_start_r <= in_if.token_start;
    end
  end

  always_comb begin
    cur_match  = s1_start_r ? '1 : match_r;
    cur_pos    = s1_start_r ? '0 : pos_r;
    cur_active = s1_start_r || active_r;

    match_nxt  = match_r;
    pos_nxt    = pos_r;
    active_nxt = active_r;
    emit       = 1'b0;
    code_nxt   = hmtr_pkg::METHOD_NOT_IMPLEMENTED;

    if (s1_fire && cur_active) begin
      match_nxt  = cur_match;
      pos_nxt    = cur_pos;
      active_nxt = 1'b1;
      if (s1_byte_r == hmtr_pkg::SPACE_BYTE) begin
        emit       = 1'b1;
        active_nxt = 1'b0;
        for (int k = hmtr_pkg::NUM_METHODS - 1; k >= 0; k--) begin
          if (cur_match[k] && hmtr_pkg::method_len(3'(k)) == cur_pos) begin
            code_nxt = hmtr_pkg::method_code_t'(4'(k + 1));
          end
        end
      end else if (cur_pos >= MAX_POS) begin
        match_nxt = '0;
      end else begin
        for (int k = 0; k < hmtr_pkg::NUM_METHODS; k++) begin
          if (!(cur_pos < hmtr_pkg::method_len(3'(k)) &&
                cur_pos < hmtr_pkg::pos_t'(hmtr_pkg::NAME_SLOTS) &&
                hmtr_pkg::method_char(3'(k), cur_pos[2:0]) == s1_byte_r)) begin
            match_nxt[k] = 1'b0;
          end
        end
        pos_nxt = cur_pos + 4'd1;
      end
    end

    out_valid_nxt = s1_fire ? emit : (out_valid_r && !out_if.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r     <= '1;
      pos_r       <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      match_r     <= match_nxt;
      pos_r       <= pos_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && emit) begin
      code_r <= code_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.method_code = code_r;

  `HMTR_ASSERT_SAME(a_code_range, out_valid_r, code_r <= hmtr_pkg::METHOD_CONNECT)
  `HMTR_ASSERT_SAME(a_pos_saturates, 1'b1, pos_r <= MAX_POS)
  `HMTR_ASSERT_NEXT(a_space_ends_token,
                    s1_fire && s1_byte_r == hmtr_pkg::SPACE_BYTE, !active_r)
  `HMTR_ASSERT_NEXT(a_emit_loads_result, s1_fire && emit, out_valid_r && code_r == $past(code_nxt))
  `HMTR_ASSERT_SAME(a_empty_stage_ready, !s1_valid_r, in_if.ready)

endmodule

`default_nettype wire
